>>> sv/byte_ngram_extractor_defines.svh
// Assertion helpers for the RTL that checks itself.
`ifndef BYTE_NGRAM_EXTRACTOR_DEFINES_SVH
`define BYTE_NGRAM_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define BNX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define BNX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/bnx_pkg.sv
`default_nettype none

package bnx_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned GRAM_W = 24;
    localparam int unsigned WIN_W  = 32;
    localparam int unsigned RUN_W  = 4;
    localparam int unsigned B64_W  = 6;

    // Gram schemes selected by the mode register
    typedef enum logic [1:0] {
        MODE_TRIGRAM = 2'd0,
        MODE_B64     = 2'd1,
        MODE_XOR     = 2'd2,
        MODE_WIDE    = 2'd3
    } index_mode_t;

    // One buffer byte as it sits in the input register
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_of_buffer;
    } bnx_item_t;

    // Extractor state, exported for checking
    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [RUN_W-1:0] run;
    } bnx_state_t;

    // Base64 decode: {is_b64, value}
    function automatic logic [B64_W:0] b64_decode(input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] t;
        t = '0;
        b64_decode = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin          // 'A'..'Z'
            t = c - 8'h41;
            b64_decode = {1'b1, t[B64_W-1:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin // 'a'..'z' -> 26..51
            t = c - 8'd71;
            b64_decode = {1'b1, t[B64_W-1:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin // '0'..'9' -> 52..61
            t = c + 8'd4;
            b64_decode = {1'b1, t[B64_W-1:0]};
        end else if (c == 8'h2B) begin               // '+'
            b64_decode = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin               // '/'
            b64_decode = {1'b1, 6'd63};
        end
    endfunction

    // Saturating run count; 15 steps back to 14 to keep the parity
    function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] r);
        run_inc = (r == 4'd15) ? 4'd14 : r + 4'd1;
    endfunction

endpackage

`default_nettype wire

>>> sv/byte_ngram_extractor.sv
`default_nettype none

// Byte n-gram extractor. Takes one buffer byte per transfer on the s_ side
// (s_tlast marks the final byte of a buffer, after which the window and run
// count return to zero) and gives at most one 24-bit gram per byte on the
// m_ side. cfg_wdata selects the scheme: 0 byte trigram, 1 base64 four-gram,
// 2 XOR hash four-gram, 3 wide-char base64; write it only while idle.
// Throughput is one byte per clock unless the output stalls: the window and
// run registers are updated once per byte. A byte's gram passes through the
// input register, then the result register, before m_tvalid. Bytes that make
// no gram produce no output transfer.

`include "byte_ngram_extractor_defines.svh"

module byte_ngram_extractor
    import bnx_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wen,
    input  wire logic [1:0]        cfg_wdata,  // [1:0] index_mode
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,    // [7:0] data_byte
    input  wire logic              s_tlast,    // last_of_buffer
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [GRAM_W-1:0]      m_tdata     // [23:0] gram_value
);

    index_mode_t       mode_reg;
    logic              item_valid;
    bnx_item_t         item;
    logic              out_free;
    logic              fire;
    logic              gram_valid;
    logic [GRAM_W-1:0] gram_value;
    bnx_state_t        state;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TRIGRAM;
        end else if (cfg_wen) begin
            mode_reg <= index_mode_t'(cfg_wdata);
        end
    end

    // A byte is processed when the result slot can take its outcome
    assign fire = item_valid && out_free;

    bnx_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    bnx_gram_unit u_gram (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .index_mode (mode_reg),
        .step       (fire),
        .item       (item),
        .gram_valid (gram_valid),
        .gram_value (gram_value),
        .state      (state)
    );

    bnx_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .load_valid (gram_valid),
        .load_value (gram_value),
        .free       (out_free),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

    // End of buffer leaves a clean window and run count
    `BNX_ASSERT_NEXT(a_last_clears, fire && item.last_of_buffer, state.window == '0 && state.run == '0, "state not cleared after last byte")

    // A new result only ever comes from a byte processed the cycle before
    `BNX_ASSERT_NOW(a_result_source, $rose(m_tvalid), $past(fire) && $past(gram_valid), "result without a processed gram")

    // Full input stage behind a stalled result must push back
    `BNX_ASSERT_NOW(a_backpressure, item_valid && m_tvalid && !m_tready, !s_tready, "input accepted while pipeline blocked")

    // Base64 schemes keep the window's top byte clear
    `BNX_ASSERT_NEXT(a_b64_window, fire && (mode_reg == MODE_B64 || mode_reg == MODE_WIDE) && state.window[WIN_W-1:GRAM_W] == '0, state.window[WIN_W-1:GRAM_W] == '0, "base64 window overflow")

endmodule

`default_nettype wire

>>> sv/bnx_in_reg.sv
`default_nettype none

module bnx_in_reg
    import bnx_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic              s_tlast,   // last_of_buffer
    input  wire logic              advance,
    output logic                   item_valid,
    output bnx_item_t              item
);

    logic      valid_reg, valid_next;
    bnx_item_t item_reg;

    // Stage is free when empty or when its byte moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture on transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= '{data_byte: s_tdata, last_of_buffer: s_tlast};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> sv/bnx_gram_unit.sv
`default_nettype none

module bnx_gram_unit
    import bnx_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire index_mode_t       index_mode,
    input  wire logic              step,
    input  wire bnx_item_t         item,
    output logic                   gram_valid,
    output logic [GRAM_W-1:0]      gram_value,
    output bnx_state_t             state
);

    logic [WIN_W-1:0] window_reg, window_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [B64_W:0]   dec;
    logic             is_b64;
    logic [B64_W-1:0] b64_val;
    logic [WIN_W-1:0] win_b64;

    assign dec     = b64_decode(item.data_byte);
    assign is_b64  = dec[B64_W];
    assign b64_val = dec[B64_W-1:0];
    // Six-bit shift into the low 24 bits; upper byte stays zero
    assign win_b64 = {{(WIN_W-GRAM_W){1'b0}}, window_reg[GRAM_W-B64_W-1:0], b64_val};

    // Per-byte update and gram for the selected scheme
    always_comb begin
        window_next = window_reg;
        run_next    = run_reg;
        gram_valid  = 1'b0;
        gram_value  = window_reg[GRAM_W-1:0];
        unique case (index_mode)
            MODE_TRIGRAM: begin
                window_next = {{(WIN_W-GRAM_W){1'b0}}, window_reg[15:0], item.data_byte};
                gram_valid  = (run_reg >= 4'd2);
                gram_value  = window_next[GRAM_W-1:0];
                run_next    = run_inc(run_reg);
            end
            MODE_B64: begin
                if (is_b64) begin
                    window_next = win_b64;
                    run_next    = run_inc(run_reg);
                end else begin
                    run_next = '0;
                end
                gram_valid = (run_next >= 4'd4);
                gram_value = window_next[GRAM_W-1:0];
            end
            MODE_XOR: begin
                window_next = {window_reg[GRAM_W-1:0], item.data_byte};
                gram_valid  = (run_reg >= 4'd3);
                gram_value  = window_next[WIN_W-1:DATA_W] ^ window_next[GRAM_W-1:0];
                run_next    = run_inc(run_reg);
            end
            MODE_WIDE: begin
                if (run_reg[0]) begin
                    // odd run: expect the zero high byte of a wide char
                    run_next   = (item.data_byte == '0) ? run_inc(run_reg) : '0;
                    gram_valid = (run_next >= 4'd8);
                end else if (is_b64) begin
                    window_next = win_b64;
                    run_next    = run_inc(run_reg);
                end else begin
                    run_next = '0;
                end
                gram_value = window_reg[GRAM_W-1:0];
            end
            default: begin
                run_next = '0;
            end
        endcase
        // End of buffer clears everything after the gram is taken
        if (item.last_of_buffer) begin
            window_next = '0;
            run_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            run_reg    <= '0;
        end else if (step) begin
            window_reg <= window_next;
            run_reg    <= run_next;
        end
    end

    assign state = '{window: window_reg, run: run_reg};

endmodule

`default_nettype wire

>>> sv/bnx_out_reg.sv
`default_nettype none

module bnx_out_reg
    import bnx_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic              load_valid,
    input  wire logic [GRAM_W-1:0] load_value,
    output logic                   free,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [GRAM_W-1:0]      m_tdata   // [23:0] gram_value
);

    logic              valid_reg, valid_next;
    logic [GRAM_W-1:0] data_reg;

    // Slot can take a new result if empty or draining now
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = load_valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid) begin
            data_reg <= load_value;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

>>> verif/tb_byte_ngram_extractor.sv
`default_nettype none

module tb_byte_ngram_extractor;
    import bnx_pkg::*;

    typedef logic [DATA_W-1:0] byte_seq_t [$];

    localparam int unsigned RANDOM_ITEMS   = 1700;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned MAX_REPORTS    = 10;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              cfg_wen  = 1'b0;
    logic [1:0]        cfg_wdata = 2'd0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;     // [7:0] data_byte
    logic              s_tlast  = 1'b0;   // last_of_buffer
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [GRAM_W-1:0] m_tdata;           // [23:0] gram_value

    // Shadow of the extractor state and mode register
    index_mode_t       mode_shadow = MODE_TRIGRAM;
    logic [31:0]       window_shadow = '0;
    logic [3:0]        run_shadow = '0;
    logic [6:0]        b64_table [256];   // {is_base64, value}

    logic [GRAM_W-1:0] expected_grams [$];
    int unsigned       fail_count = 0;
    int unsigned       quiet_cycles = 0;
    bit                sender_burst = 1'b0;
    bit                receiver_burst = 1'b0;

    byte_ngram_extractor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Base64 alphabet: value -> character
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'h41 + {2'b00, v};            // 'A'..'Z'
        else if (v < 6'd52)
            return 8'h61 + {2'b00, v} - 8'd26;    // 'a'..'z'
        else if (v < 6'd62)
            return 8'h30 + {2'b00, v} - 8'd52;    // '0'..'9'
        else if (v == 6'd62)
            return 8'h2B;                         // '+'
        else
            return 8'h2F;                         // '/'
    endfunction

    // Run counter saturates at 15 and falls back to 14 to keep parity
    function automatic logic [3:0] run_bump(input logic [3:0] r);
        return (r == 4'd15) ? 4'd14 : r + 4'd1;
    endfunction

    // Update the shadow state for one byte; queue the gram it yields, if any
    task automatic predict_gram(input logic [7:0] b, input logic lst);
        logic [6:0]  code;
        logic        hit;
        logic [23:0] gram;
        code = b64_table[b];
        hit  = 1'b0;
        gram = '0;
        case (mode_shadow)
            MODE_TRIGRAM: begin
                window_shadow = {8'h00, window_shadow[15:0], b};
                if (run_shadow >= 4'd2) begin
                    hit  = 1'b1;
                    gram = window_shadow[23:0];
                end
                run_shadow = run_bump(run_shadow);
            end
            MODE_B64: begin
                if (!code[6]) begin
                    run_shadow = '0;
                end else begin
                    window_shadow = {8'h00, window_shadow[17:0], code[5:0]};
                    run_shadow    = run_bump(run_shadow);
                end
                if (run_shadow >= 4'd4) begin
                    hit  = 1'b1;
                    gram = window_shadow[23:0];
                end
            end
            MODE_XOR: begin
                window_shadow = {window_shadow[23:0], b};
                if (run_shadow >= 4'd3) begin
                    hit  = 1'b1;
                    gram = window_shadow[31:8] ^ window_shadow[23:0];
                end
                run_shadow = run_bump(run_shadow);
            end
            MODE_WIDE: begin
                // odd run: expect the zero half of a wide character
                if (run_shadow[0]) begin
                    run_shadow = (b == 8'h00) ? run_bump(run_shadow) : 4'd0;
                    if (run_shadow >= 4'd8) begin
                        hit  = 1'b1;
                        gram = window_shadow[23:0];
                    end
                end else if (!code[6]) begin
                    run_shadow = '0;
                end else begin
                    window_shadow = {8'h00, window_shadow[17:0], code[5:0]};
                    run_shadow    = run_bump(run_shadow);
                end
            end
        endcase
        if (hit)
            expected_grams = {expected_grams, gram};
        if (lst) begin
            window_shadow = '0;
            run_shadow    = '0;
        end
    endtask

    // One byte over the input channel, after a random gap outside sender bursts
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        predict_gram(b, lst);
    endtask

    // A whole buffer, last byte marked
    task automatic send_buffer(input byte_seq_t seq);
        int unsigned k;
        for (k = 0; k < seq.size(); k++)
            send_byte(seq[k], k == seq.size() - 1);
    endtask

    // Mode write once every gram is out and the pipeline has drained
    task automatic set_mode(input index_mode_t m);
        s_tvalid <= 1'b0;
        while (expected_grams.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_wen     <= 1'b0;
        mode_shadow = m;
    endtask

    task automatic test_trigram();
        set_mode(MODE_TRIGRAM);
        // too short for a trigram
        send_buffer('{8'hFF, 8'h00});
        send_buffer('{8'h00, 8'hFF, 8'h80, 8'h7F});
    endtask

    task automatic test_b64();
        set_mode(MODE_B64);
        // run broken by '-' then restarted
        send_buffer('{8'h41, 8'h2F, 8'h2B, 8'h39, 8'h7A, 8'h2D, 8'h51});
    endtask

    task automatic test_xor();
        set_mode(MODE_XOR);
        send_buffer('{8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF});
    endtask

    task automatic test_wide();
        set_mode(MODE_WIDE);
        // "Az/9+" as wide chars, last zero slot holds a wrong byte
        send_buffer('{8'h41, 8'h00, 8'h7A, 8'h00, 8'h2F, 8'h00, 8'h39, 8'h00,
                      8'h2B, 8'h01});
    endtask

    // Random content shaped for the selected scheme
    function automatic logic [7:0] pick_byte(input index_mode_t m, input int unsigned pos);
        case (m)
            MODE_B64:
                if ($urandom_range(0, 11) == 0)
                    return 8'($urandom_range(0, 255));
                else
                    return b64_char(6'($urandom_range(0, 63)));
            MODE_WIDE:
                if ($urandom_range(0, 15) == 0)
                    return 8'($urandom_range(0, 255));
                else if (pos[0])
                    return 8'h00;
                else
                    return b64_char(6'($urandom_range(0, 63)));
            default:
                return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Phases of random buffers; some phases stop mid-buffer before a mode change
    task automatic test_random();
        int unsigned sent;
        int unsigned phase;
        int unsigned budget;
        int unsigned len;
        int unsigned k;
        bit          cut;
        index_mode_t m;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            m = (phase < 4) ? index_mode_t'(phase) : index_mode_t'($urandom_range(0, 3));
            set_mode(m);
            sender_burst   = ($urandom_range(0, 3) == 0);
            receiver_burst = ($urandom_range(0, 3) == 0);
            budget = $urandom_range(60, 160);
            cut    = ($urandom_range(0, 2) == 0);
            while (budget != 0) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48)
                                                  : $urandom_range(1, 24);
                for (k = 0; k < len && budget != 0; k++) begin
                    send_byte(pick_byte(m, k), (k == len - 1) || (budget == 1 && !cut));
                    budget--;
                    sent++;
                end
            end
            phase++;
        end
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
    endtask

    // Output channel backpressure, one draw per result
    initial begin
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            stall = receiver_burst ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare each gram transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grams.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected gram: got %h", m_tdata);
            end else begin
                if (m_tdata !== expected_grams[0]) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("gram mismatch: expected %h got %h",
                                 expected_grams[0], m_tdata);
                end
                void'(expected_grams.pop_front());
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** byte_ngram_extractor: FAILED **");
        $finish;
    end

    initial begin
        int unsigned v;
        for (v = 0; v < 256; v++)
            b64_table[v] = '0;
        for (v = 0; v < 64; v++)
            b64_table[b64_char(6'(v))] = {1'b1, 6'(v)};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_trigram();
        test_b64();
        test_xor();
        test_wide();
        test_random();

        // drain and settle
        s_tvalid <= 1'b0;
        while (expected_grams.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && expected_grams.size() == 0) begin
            $display("** byte_ngram_extractor: PASSED **");
        end else begin
            $display("** byte_ngram_extractor: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
